// ===== sv/md5_pkg.sv =====
`timescale 1ns / 1ps

package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Byte index where the little-endian bit length starts in the last block.
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [31:0] K_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] SHIFT_TABLE [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [1:0] {
		PAD_KIND_80,
		PAD_KIND_ZERO,
		PAD_KIND_LEN
	} pad_kind_t;

	typedef struct packed {
		logic       wr_en;     // write one byte at the fill pointer
		logic       wr_pad;    // byte comes from the padding logic, not the input
		pad_kind_t  pad_kind;
		logic       rd_en;     // fetch the message word for rd_step
		logic [5:0] rd_step;
		logic       load_work; // copy chaining words into the working registers
		logic       round_en;  // run one compression step
		logic [5:0] step;
		logic       add_en;    // fold working registers into the chaining words
		logic       finish;    // capture the digest and restart the message
		logic [1:0] out_idx;
	} md5_cmd_t;

	typedef struct packed {
		logic ptr_last; // fill pointer on the last byte of the block
		logic ptr_lt56; // fill pointer below the length field
	} md5_stat_t;

	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] j;
		logic [3:0] g;
		j = step[3:0];
		case (step[5:4])
			2'd0: g = j;
			2'd1: g = 4'(5 * j + 1);
			2'd2: g = 4'(3 * j + 5);
			default: g = 4'(7 * j);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_fn(input logic [1:0] rnd,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (rnd)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

endpackage

// ===== sv/md5_datapath.sv =====
`timescale 1ns / 1ps

module md5_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::md5_cmd_t cmd,
	input  logic [7:0]        data_byte,
	output md5_pkg::md5_stat_t stat,
	output logic [31:0]       digest_word
);
	import md5_pkg::*;

	logic [31:0] mem [16];
	logic [31:0] rdata_q;
	logic [5:0]  ptr_q;
	logic [63:0] bit_count_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] dig_q [4];

	logic [7:0]  pad_byte;
	logic [7:0]  wr_byte;
	logic [31:0] t_sum;
	logic [63:0] rot_wide;
	logic [31:0] b_next;

	always_comb begin
		case (cmd.pad_kind)
			PAD_KIND_80: pad_byte = PAD_BYTE;
			PAD_KIND_LEN: pad_byte = bit_count_q[{ptr_q[2:0], 3'b000} +: 8];
			default: pad_byte = 8'h00;
		endcase
		wr_byte = cmd.wr_pad ? pad_byte : data_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[ptr_q[5:2]][{ptr_q[1:0], 3'b000} +: 8] <= wr_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[msg_index(cmd.rd_step)];
		end
	end

	always_comb begin
		t_sum = a_q + round_fn(cmd.step[5:4], b_q, c_q, d_q) + rdata_q + K_TABLE[cmd.step];
		rot_wide = {t_sum, t_sum} << SHIFT_TABLE[{cmd.step[5:4], cmd.step[1:0]}];
		b_next = b_q + rot_wide[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			bit_count_q <= '0;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
		end else begin
			if (cmd.wr_en) begin
				ptr_q <= ptr_q + 6'd1;
			end
			if (cmd.wr_en && !cmd.wr_pad) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.add_en) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
			if (cmd.finish) begin
				ptr_q <= '0;
				bit_count_q <= '0;
				chain_q[0] <= INIT_A;
				chain_q[1] <= INIT_B;
				chain_q[2] <= INIT_C;
				chain_q[3] <= INIT_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			b_q <= b_next;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (cmd.finish) begin
			dig_q[0] <= chain_q[0] + a_q;
			dig_q[1] <= chain_q[1] + b_q;
			dig_q[2] <= chain_q[2] + c_q;
			dig_q[3] <= chain_q[3] + d_q;
		end
	end

	assign stat.ptr_last = (ptr_q == 6'd63);
	assign stat.ptr_lt56 = (ptr_q < LEN_POS);
	assign digest_word = dig_q[cmd.out_idx];

endmodule

// ===== sv/md5_ctrl.sv =====
`timescale 1ns / 1ps

module md5_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               has_byte,
	input  logic               end_of_message,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  md5_pkg::md5_stat_t stat,
	output md5_pkg::md5_cmd_t  cmd
);
	import md5_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_CLOAD,
		ST_CROUND,
		ST_CADD
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       pend_end_q;
	logic       sent80_q;
	logic       len_ok_q;
	logic       out_busy_q;
	logic [1:0] out_idx_q;

	logic accept;
	logic final_blk;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign final_blk = sent80_q && len_ok_q;
	assign out_valid = out_busy_q;

	always_comb begin
		cmd = '0;
		cmd.pad_kind = PAD_KIND_ZERO;
		cmd.step = cnt_q;
		cmd.out_idx = out_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_en = accept && has_byte;
			end
			ST_PAD: begin
				cmd.wr_en = 1'b1;
				cmd.wr_pad = 1'b1;
				if (!sent80_q) begin
					cmd.pad_kind = PAD_KIND_80;
				end else if (len_ok_q && !stat.ptr_lt56) begin
					cmd.pad_kind = PAD_KIND_LEN;
				end
			end
			ST_CLOAD: begin
				cmd.rd_en = 1'b1;
				cmd.load_work = 1'b1;
			end
			ST_CROUND: begin
				cmd.round_en = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_step = cnt_q + 6'd1;
			end
			ST_CADD: begin
				cmd.finish = final_blk && !out_busy_q;
				cmd.add_en = !final_blk;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pend_end_q <= 1'b0;
			sent80_q <= 1'b0;
			len_ok_q <= 1'b0;
			out_busy_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (out_busy_q && out_ready) begin
				out_idx_q <= out_idx_q + 2'd1;
				if (out_idx_q == 2'd3) begin
					out_busy_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_byte && stat.ptr_last) begin
							pend_end_q <= end_of_message;
							state_q <= ST_CLOAD;
						end else if (end_of_message) begin
							sent80_q <= 1'b0;
							len_ok_q <= 1'b0;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!sent80_q) begin
						sent80_q <= 1'b1;
						len_ok_q <= stat.ptr_lt56;
					end
					if (stat.ptr_last) begin
						state_q <= ST_CLOAD;
					end
				end
				ST_CLOAD: begin
					cnt_q <= '0;
					state_q <= ST_CROUND;
				end
				ST_CROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_CADD;
					end
				end
				ST_CADD: begin
					if (final_blk) begin
						// The previous digest must be fully sent before this one lands.
						if (!out_busy_q) begin
							out_busy_q <= 1'b1;
							out_idx_q <= '0;
							sent80_q <= 1'b0;
							len_ok_q <= 1'b0;
							pend_end_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else if (sent80_q) begin
						// The pad byte spilled past the length field: one more block.
						len_ok_q <= 1'b1;
						state_q <= ST_PAD;
					end else if (pend_end_q) begin
						pend_end_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/md5_message_digest_unit.sv =====
`timescale 1ns / 1ps

// MD5 digest over a byte stream.
// Input channel s_*: one request per cycle while idle; s_tdata[7:0] is a
// message byte, valid when s_tuser[0] is set, and s_tlast ends the message.
// Output channel m_*: four requests per message, digest words A, B, C, D,
// with the word number on m_tuser and m_tlast on word D.
// Every 64th byte starts a compression (word fetch, 64 rounds through one
// round unit, final add), during which s_tready is low. End of message
// writes pad bytes one per cycle to the end of the block through the single
// byte write port, then compresses, twice when the length does not fit.
// The digest sits in its own registers, so the next message is taken while
// the receiver stalls; only a second digest waits for the first.
// Reset puts the chaining words at their initial values and clears the
// byte and bit counters.
module md5_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_tuser,  // [0] has_byte
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [1:0]  m_tuser,  // [1:0] word_index
	output logic        m_tlast   // last_word
);
	import md5_pkg::*;

	md5_cmd_t  cmd;
	md5_stat_t stat;

	md5_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.has_byte       (s_tuser[0]),
		.end_of_message (s_tlast),
		.in_ready       (s_tready),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.stat           (stat),
		.cmd            (cmd)
	);

	md5_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (s_tdata),
		.stat        (stat),
		.digest_word (m_tdata)
	);

	assign m_tuser = cmd.out_idx;
	assign m_tlast = (cmd.out_idx == 2'd3);

`ifndef SYNTH
	a_no_write_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> !cmd.wr_en)
		else $error("block buffer written during a compression round");

	a_no_digest_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !m_tvalid)
		else $error("digest captured while previous digest still pending");

	a_no_input_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> !s_tready)
		else $error("input taken during compression");
`endif

endmodule
